// ----- src/gds_pkg.sv -----
package gds_pkg;

  localparam int WEIGHT_W   = 24;
  localparam int LIMIT_W    = 23;
  localparam int COUNT_W    = 4;
  localparam int PUMP_W     = 5;
  localparam int SETTLE_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_BAND    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_PUMP    = 2'd3;

  localparam logic [LIMIT_W-1:0] GLITCH_LIMIT_RST = 23'd2000;
  localparam logic [LIMIT_W-1:0] SLOW_BAND_RST    = 23'd200;
  localparam logic [COUNT_W-1:0] SETTLE_COUNT_RST = 4'd3;
  localparam logic [COUNT_W-1:0] LAST_PUMP_RST    = 4'd9;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_FAST = 2'd1,
    CMD_SLOW = 2'd2,
    CMD_STOP = 2'd3
  } cmd_t;

  localparam logic signed [WEIGHT_W-1:0] W_MAX = 24'sh7FFFFF;
  localparam logic signed [WEIGHT_W-1:0] W_MIN = 24'sh800000;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic [COUNT_W-1:0]          target_index;
    logic signed [WEIGHT_W-1:0]  target_value;
    logic signed [WEIGHT_W-1:0]  weight;
    logic                        reading_valid;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [PUMP_W-1:0] pump_index;
    logic              reading_accepted;
    logic              sequence_done;
  } out_item_t;

endpackage

// ----- src/gds_chan_if.sv -----
interface gds_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/gravimetric_dosing_sequencer.sv -----
// Gravimetric dosing sequencer.
// in_ch carries requests: load a pump target, start the sequence, or a scale
// sample. out_ch returns one status item per request: last command, current
// pump, whether the sample was taken and whether the sequence is done.
// The cfg_ port writes glitch limit, slow band, settle count and last pump;
// write only while no request is in flight.
// A request is held in the input register, and its status is then captured
// in the output register. Throughput: one request per cycle while out_ch is
// not stalled; the input register feeds a single pass of compare/add logic
// that updates pump state and the output register in the same cycle.
// When out_ch is stalled the status is held in the output register, one more
// request waits in the input register, and in_ch.ready drops.
// Reset clears pump index, settle counter, last weight and command, and loads
// the default register values. Pump targets are undefined until loaded.
module gravimetric_dosing_sequencer
  import gds_pkg::*;
#(
  parameter int MAX_PUMPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gds_chan_if.sink              in_ch,
  gds_chan_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_PUMPS > 1) ? $clog2(MAX_PUMPS) : 1;
  localparam int XW = (AW > PUMP_W) ? AW : PUMP_W;

  logic [LIMIT_W-1:0] glitch_limit_r;
  logic [LIMIT_W-1:0] slow_band_r;
  logic [COUNT_W-1:0] settle_count_r;
  logic [COUNT_W-1:0] last_pump_r;

  logic signed [WEIGHT_W-1:0] tgt_tbl_r [MAX_PUMPS];
  logic signed [WEIGHT_W-1:0] cur_tgt_r, cur_tgt_nxt;
  logic [PUMP_W-1:0]          pump_r, pump_nxt;
  logic [SETTLE_W-1:0]        settle_r, settle_nxt;
  logic signed [WEIGHT_W-1:0] past_w_r, past_w_nxt;
  cmd_t                       cmd_r, cmd_nxt;

  logic      s1_valid_r;
  in_item_t  s1_r;
  logic      out_valid_r;
  out_item_t out_r;
  out_item_t res;

  logic out_free, fire;

  logic [PUMP_W-1:0]          pump_inc;
  logic [XW-1:0]              inc_ext, tidx_ext;
  logic [AW-1:0]              rd_idx;
  logic signed [WEIGHT_W-1:0] rd_data;
  logic                       inc_in_tbl;
  logic                       tw_en;
  logic [AW-1:0]              tw_idx;
  logic signed [WEIGHT_W-1:0] tw_data;

  logic signed [WEIGHT_W:0]   diff;
  logic [WEIGHT_W:0]          diff_abs;
  logic signed [WEIGHT_W-1:0] tgt_eff;
  logic signed [WEIGHT_W+1:0] slow_floor;
  logic signed [WEIGHT_W:0]   sum;
  logic signed [WEIGHT_W-1:0] sum_sat;
  logic [SETTLE_W-1:0]        settle_inc;
  logic                       active, accepted;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign fire         = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign pump_inc   = pump_r + PUMP_W'(1);
  assign inc_ext    = XW'(pump_inc);
  assign tidx_ext   = XW'(s1_r.target_index);
  assign inc_in_tbl = int'(pump_inc) < MAX_PUMPS;
  assign rd_idx     = (s1_r.opcode == OP_START) ? AW'(0) : inc_ext[AW-1:0];
  assign rd_data    = tgt_tbl_r[rd_idx];

  always_comb begin
    pump_nxt    = pump_r;
    settle_nxt  = settle_r;
    past_w_nxt  = past_w_r;
    cmd_nxt     = cmd_r;
    cur_tgt_nxt = cur_tgt_r;
    tw_en       = 1'b0;
    tw_idx      = tidx_ext[AW-1:0];
    tw_data     = s1_r.target_value;
    accepted    = 1'b0;

    diff       = $signed({past_w_r[WEIGHT_W-1], past_w_r})
                 - $signed({s1_r.weight[WEIGHT_W-1], s1_r.weight});
    diff_abs   = diff[WEIGHT_W] ? (WEIGHT_W+1)'(-diff) : (WEIGHT_W+1)'(diff);
    tgt_eff    = (int'(pump_r) < MAX_PUMPS) ? cur_tgt_r : '0;
    slow_floor = $signed({{2{tgt_eff[WEIGHT_W-1]}}, tgt_eff})
                 - $signed({3'b000, slow_band_r});
    sum        = $signed({rd_data[WEIGHT_W-1], rd_data})
                 + $signed({s1_r.weight[WEIGHT_W-1], s1_r.weight});
    if (sum > $signed({W_MAX[WEIGHT_W-1], W_MAX})) begin
      sum_sat = W_MAX;
    end else if (sum < $signed({W_MIN[WEIGHT_W-1], W_MIN})) begin
      sum_sat = W_MIN;
    end else begin
      sum_sat = sum[WEIGHT_W-1:0];
    end
    settle_inc = settle_r + SETTLE_W'(1);
    active     = pump_r <= PUMP_W'(last_pump_r);

    case (s1_r.opcode)
      OP_LOAD: begin
        if (int'(s1_r.target_index) < MAX_PUMPS) begin
          tw_en = 1'b1;
          if (tidx_ext == XW'(pump_r)) begin
            cur_tgt_nxt = s1_r.target_value;
          end
        end
      end
      OP_START: begin
        pump_nxt    = '0;
        settle_nxt  = '0;
        past_w_nxt  = '0;
        cur_tgt_nxt = rd_data;
      end
      OP_SAMPLE: begin
        if (active && s1_r.reading_valid
            && diff_abs < (WEIGHT_W+1)'(glitch_limit_r)) begin
          accepted   = 1'b1;
          past_w_nxt = s1_r.weight;
          if (s1_r.weight < tgt_eff) begin
            if ($signed({{2{s1_r.weight[WEIGHT_W-1]}}, s1_r.weight}) > slow_floor) begin
              cmd_nxt = CMD_SLOW;
            end else begin
              cmd_nxt = CMD_FAST;
            end
          end else begin
            cmd_nxt    = CMD_STOP;
            settle_nxt = settle_inc;
            if (settle_inc > SETTLE_W'(settle_count_r)) begin
              settle_nxt  = '0;
              pump_nxt    = pump_inc;
              cur_tgt_nxt = inc_in_tbl ? rd_data : '0;
              if (inc_in_tbl && pump_inc <= PUMP_W'(last_pump_r)) begin
                tw_en       = 1'b1;
                tw_idx      = inc_ext[AW-1:0];
                tw_data     = sum_sat;
                cur_tgt_nxt = sum_sat;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    res.command          = cmd_nxt;
    res.pump_index       = pump_nxt;
    res.reading_accepted = accepted;
    res.sequence_done    = pump_nxt > PUMP_W'(last_pump_r);
  end

  always_ff @(posedge clk) begin
    if (fire && tw_en) begin
      tgt_tbl_r[tw_idx] <= tw_data;
    end
    if (fire) begin
      cur_tgt_r <= cur_tgt_nxt;
      out_r     <= res;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      pump_r         <= '0;
      settle_r       <= '0;
      past_w_r       <= '0;
      cmd_r          <= CMD_NONE;
      glitch_limit_r <= GLITCH_LIMIT_RST;
      slow_band_r    <= SLOW_BAND_RST;
      settle_count_r <= SETTLE_COUNT_RST;
      last_pump_r    <= LAST_PUMP_RST;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        pump_r      <= pump_nxt;
        settle_r    <= settle_nxt;
        past_w_r    <= past_w_nxt;
        cmd_r       <= cmd_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLITCH_LIMIT: glitch_limit_r <= cfg_wdata[LIMIT_W-1:0];
          CFG_SLOW_BAND:    slow_band_r    <= cfg_wdata[LIMIT_W-1:0];
          CFG_SETTLE_COUNT: settle_count_r <= cfg_wdata[COUNT_W-1:0];
          CFG_LAST_PUMP:    last_pump_r    <= cfg_wdata[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule
